>>> rtl/pdc_pkg.sv
// Shared types, constants and the CRC byte step for the packet deframer.
package pdc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam int unsigned HDR_FIELDS      = 6;   // header bytes kept before the length
  localparam int unsigned PAY_AW_MAX      = 6;   // address bits for the largest payload
  localparam int unsigned EVQ_DEPTH       = 2;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  typedef enum logic [2:0] {
    PH_SOF0,
    PH_SOF1,
    PH_HDR,
    PH_PAY,
    PH_CRCL,
    PH_CRCH
  } phase_e;

  typedef enum logic [2:0] {
    EV_PKT,
    EV_VER,
    EV_CRC,
    EV_LEN,
    EV_NADDR
  } event_e;

  typedef enum logic [2:0] {
    CFG_SELF,
    CFG_BCAST,
    CFG_VERSION,
    CFG_SOF0,
    CFG_SOF1,
    CFG_CRC_INIT
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  self_node;
    logic [7:0]  bcast_node;
    logic [7:0]  version;
    logic [7:0]  sof0;
    logic [7:0]  sof1;
    logic [15:0] crc_init;
  } cfg_t;

  typedef struct packed {
    event_e          kind;
    logic [5:0][7:0] hdr;   // version, source, destination, type, flags, sequence
    logic [6:0]      len;
  } desc_t;

  typedef struct packed {
    logic                  we;
    logic [PAY_AW_MAX-1:0] addr;
    logic [7:0]            data;
  } pay_wr_t;

  typedef struct packed {
    event_e          kind;
    logic [5:0][7:0] hdr;
    logic [6:0]      len;
    logic [7:0]      pbyte;
    logic [5:0]      idx;
    logic            last;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/packet_deframer_crc_check_core.sv
// Top level of the packet deframer with CRC-16 check: config registers and stream ports.
// Input: one word per cycle; a payload word waits while an event is queued or a replay is
//   running, a length or high trailer word waits while the two-entry queue is full.
// Output: a single-word event passes the event queue and the output register; a replay
//   runs one word per cycle from the payload memory while the receiver takes each word.
// Reset (async, active low) clears control and sets config registers to defaults;
//   the payload memory is not cleared.
module packet_deframer_crc_check_core #(
  parameter int unsigned MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // version, source, destination, message_type, flag_bits, sequence_res,
  // payload_length, payload_byte, byte_index, zero pad
  output logic [71:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // event_kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import pdc_pkg::*;

  cfg_t    cfg_q;
  logic    push;
  desc_t   push_desc;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  desc_t   q_desc;
  logic    back_busy;
  pay_wr_t pay_wr;
  res_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.self_node  <= 8'd0;
      cfg_q.bcast_node <= 8'd255;
      cfg_q.version    <= 8'd1;
      cfg_q.sof0       <= 8'hA5;
      cfg_q.sof1       <= 8'h5A;
      cfg_q.crc_init   <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_SELF:     cfg_q.self_node  <= cfg_wdata_i[7:0];
        CFG_BCAST:    cfg_q.bcast_node <= cfg_wdata_i[7:0];
        CFG_VERSION:  cfg_q.version    <= cfg_wdata_i[7:0];
        CFG_SOF0:     cfg_q.sof0       <= cfg_wdata_i[7:0];
        CFG_SOF1:     cfg_q.sof1       <= cfg_wdata_i[7:0];
        CFG_CRC_INIT: cfg_q.crc_init   <= cfg_wdata_i;
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  pdc_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .q_full_i      (q_full),
    .replay_busy_i (back_busy || q_valid),
    .push_o        (push),
    .desc_o        (push_desc),
    .pay_wr_o      (pay_wr)
  );

  pdc_evq u_evq (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .desc_o  (q_desc)
  );

  pdc_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i,
    .rst_ni,
    .pay_wr_i    (pay_wr),
    .q_valid_i   (q_valid),
    .q_desc_i    (q_desc),
    .q_pop_o     (q_pop),
    .busy_o      (back_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.idx, res.pbyte, res.len, res.hdr};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

>>> rtl/pdc_front.sv
// Front part: start-byte hunt, header capture, CRC, payload write and event classification.
module pdc_front #(
  parameter int unsigned MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pdc_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             q_full_i,
  input  logic             replay_busy_i,
  output logic             push_o,
  output pdc_pkg::desc_t   desc_o,
  output pdc_pkg::pay_wr_t pay_wr_o
);
  import pdc_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  phase_e          phase_q, phase_d;
  logic [6:0]      pos_q;
  logic [6:0]      len_q;
  logic [5:0][7:0] hdr_q;
  logic [15:0]     crc_q;
  logic [7:0]      crc_lo_q;

  logic        acc;
  logic        hdr_end;
  logic        len_bad;
  logic        pay_end;
  logic [15:0] crc_next;
  logic [15:0] crc_got;

  assign acc      = in_valid_i & in_ready_o;
  assign hdr_end  = (pos_q == 7'(HDR_FIELDS));
  assign len_bad  = (in_byte_i > MaxLen);
  assign pay_end  = ((pos_q + 7'd1) == len_q);
  assign crc_next = crc16_byte(crc_q, in_byte_i);
  assign crc_got  = {in_byte_i, crc_lo_q};

  // Hold the length word or the high trailer word while the queue is full; hold payload
  // while a replay still needs the payload memory.
  always_comb begin
    case (phase_q)
      PH_HDR:  in_ready_o = !(hdr_end && q_full_i);
      PH_CRCH: in_ready_o = !q_full_i;
      PH_PAY:  in_ready_o = !replay_busy_i;
      default: in_ready_o = 1'b1;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      case (phase_q)
        PH_SOF1: begin
          if (in_byte_i == cfg_i.sof1) begin
            phase_d = PH_HDR;
          end else if (in_byte_i != cfg_i.sof0) begin
            phase_d = PH_SOF0;
          end
        end
        PH_HDR: begin
          if (hdr_end) begin
            if (len_bad) begin
              phase_d = PH_SOF0;
            end else if (in_byte_i == 8'd0) begin
              phase_d = PH_CRCL;
            end else begin
              phase_d = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          if (pay_end) begin
            phase_d = PH_CRCL;
          end
        end
        PH_CRCL: phase_d = PH_CRCH;
        PH_CRCH: phase_d = PH_SOF0;
        default: phase_d = (in_byte_i == cfg_i.sof0) ? PH_SOF1 : PH_SOF0;
      endcase
    end
  end

  always_comb begin
    push_o        = 1'b0;
    desc_o.kind   = EV_PKT;
    desc_o.hdr    = hdr_q;
    desc_o.len    = len_q;
    pay_wr_o.we   = 1'b0;
    pay_wr_o.addr = pos_q[PAY_AW_MAX-1:0];
    pay_wr_o.data = in_byte_i;
    case (phase_q)
      PH_HDR: begin
        push_o      = acc && hdr_end && len_bad;
        desc_o.kind = EV_LEN;
        desc_o.len  = in_byte_i[7] ? 7'h7F : in_byte_i[6:0];
      end
      PH_PAY: begin
        pay_wr_o.we = acc;
      end
      PH_CRCH: begin
        push_o = acc;
        if (crc_got != crc_q) begin
          desc_o.kind = EV_CRC;
        end else if (hdr_q[2] != cfg_i.self_node && hdr_q[2] != cfg_i.bcast_node) begin
          desc_o.kind = EV_NADDR;
        end else if (hdr_q[0] != cfg_i.version) begin
          desc_o.kind = EV_VER;
        end else begin
          desc_o.kind = EV_PKT;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SOF0;
      pos_q    <= '0;
      len_q    <= '0;
      hdr_q    <= '0;
      crc_q    <= 16'hFFFF;
      crc_lo_q <= '0;
    end else begin
      phase_q <= phase_d;
      if (acc) begin
        case (phase_q)
          PH_SOF1: begin
            if (in_byte_i == cfg_i.sof1) begin
              pos_q <= '0;
              crc_q <= cfg_i.crc_init;
            end
          end
          PH_HDR: begin
            crc_q <= crc_next;
            if (!hdr_end) begin
              hdr_q[pos_q[2:0]] <= in_byte_i;
              pos_q             <= pos_q + 7'd1;
            end else begin
              pos_q <= '0;
              len_q <= len_bad ? 7'd0 : in_byte_i[6:0];
            end
          end
          PH_PAY: begin
            crc_q <= crc_next;
            pos_q <= pay_end ? 7'd0 : pos_q + 7'd1;
          end
          PH_CRCL: crc_lo_q <= in_byte_i;
          PH_CRCH: pos_q <= '0;
          default: pos_q <= pos_q;
        endcase
      end
    end
  end

endmodule

>>> rtl/pdc_evq.sv
// Two-entry event queue between the front and back parts.
module pdc_evq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdc_pkg::desc_t desc_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output pdc_pkg::desc_t desc_o
);
  import pdc_pkg::*;

  localparam int unsigned PtrW = $clog2(EVQ_DEPTH);
  localparam int unsigned CntW = $clog2(EVQ_DEPTH + 1);

  desc_t            ents [EVQ_DEPTH];
  logic [PtrW-1:0]  wptr_q;
  logic [PtrW-1:0]  rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(EVQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign desc_o  = ents[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ents[wptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/pdc_back.sv
// Back part: payload memory, replay of good packets and the output register.
module pdc_back #(
  parameter int unsigned MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pdc_pkg::pay_wr_t pay_wr_i,
  input  logic             q_valid_i,
  input  pdc_pkg::desc_t   q_desc_i,
  output logic             q_pop_o,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdc_pkg::res_t    out_o
);
  import pdc_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0] pay_mem [MAX_PAYLOAD];
  logic [7:0] rdata_q;

  logic       busy_q;
  logic [6:0] cnt_q;
  desc_t      cur_q;
  logic       s1_v_q;
  logic [5:0] s1_idx_q;
  logic       s1_last_q;
  logic       out_v_q;
  res_t       out_q;

  logic s2_ok;
  logic s1_to_s2;
  logic issue;
  logic issue_last;
  logic start_replay;

  assign s2_ok        = !out_v_q || out_ready_i;
  assign s1_to_s2     = s1_v_q && s2_ok;
  assign issue        = busy_q && (!s1_v_q || s1_to_s2);
  assign issue_last   = ((cnt_q + 7'd1) == cur_q.len);
  assign q_pop_o      = !busy_q && !s1_v_q && q_valid_i && s2_ok;
  assign start_replay = q_pop_o && (q_desc_i.kind == EV_PKT) && (q_desc_i.len != 7'd0);

  assign busy_o      = busy_q;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (pay_wr_i.we) begin
      pay_mem[pay_wr_i.addr[AW-1:0]] <= pay_wr_i.data;
    end
    if (issue) begin
      rdata_q <= pay_mem[cnt_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (start_replay) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 7'd1;
        if (issue_last) begin
          busy_q <= 1'b0;
        end
      end
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_to_s2) begin
        s1_v_q <= 1'b0;
      end
      if (s1_to_s2 || (q_pop_o && !start_replay)) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_desc_i;
    end
    if (issue) begin
      s1_idx_q  <= cnt_q[5:0];
      s1_last_q <= issue_last;
    end
    if (s1_to_s2) begin
      out_q.kind  <= EV_PKT;
      out_q.hdr   <= cur_q.hdr;
      out_q.len   <= cur_q.len;
      out_q.pbyte <= rdata_q;
      out_q.idx   <= s1_idx_q;
      out_q.last  <= s1_last_q;
    end else if (q_pop_o && !start_replay) begin
      // single-word event: error, foreign packet or empty good packet
      out_q.kind  <= q_desc_i.kind;
      out_q.hdr   <= q_desc_i.hdr;
      out_q.len   <= q_desc_i.len;
      out_q.pbyte <= '0;
      out_q.idx   <= '0;
      out_q.last  <= 1'b1;
    end
  end

endmodule

>>> rtl/pdc_checker.sv
// Port-level checker for the packet deframer, bound to the top level.
module pdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import pdc_pkg::*;

  logic [6:0] len;
  logic [5:0] idx;
  logic [7:0] pbyte;

  assign len   = m_axis_tdata[54:48];
  assign pbyte = m_axis_tdata[62:55];
  assign idx   = m_axis_tdata[68:63];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_event_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_PKT |-> m_axis_tlast && pbyte == 8'd0 && idx == 6'd0)
    else $error("event word is not a single last word");

  a_replay_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == EV_PKT && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser == EV_PKT && idx == $past(idx) + 6'd1)
    else $error("replay gap or index skip");

  a_replay_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_PKT && m_axis_tlast |->
      ({1'b0, idx} + 7'd1 == len) || (len == 7'd0 && idx == 6'd0))
    else $error("replay ends at the wrong index");

endmodule

bind packet_deframer_crc_check_core pdc_checker u_pdc_checker (.*);

>>> dv/packet_deframer_crc_check_core_tb.sv
// Testbench for the packet deframer: framed byte stream in, checked replay and event words out.
module packet_deframer_crc_check_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdc_pkg::*;

  localparam int unsigned PAY_MAX  = MAX_PAYLOAD_DEF;
  localparam int unsigned TAIL     = 16;
  localparam int unsigned HOLD_OFF = 400;

  // one output word as the block should present it
  typedef struct packed {
    event_e          kind;
    logic [5:0][7:0] hdr;   // version, source, destination, type, flags, sequence
    logic [6:0]      len;
    logic [7:0]      pbyte;
    logic [5:0]      idx;
    logic            last;
  } deframe_word_t;

  // recipe for one frame on the link
  typedef struct packed {
    logic [1:0] n_sof;      // copies of the first start byte
    logic       broken;     // lead with a start byte pair that falls apart
    logic [7:0] ver;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] mtype;
    logic [7:0] flags;
    logic [7:0] seq;
    logic [7:0] len;
    logic [7:0] pay_base;
    logic [7:0] pay_step;
    logic [1:0] crc_fault;  // 1 corrupts the low trailer byte, 2 the high one
    logic [6:0] cut;        // nonzero: stop after this many bytes
    logic       typed;      // expected word written out by hand
    event_e     kind;
  } frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = CFG_SELF;
  logic [15:0] cfg_wdata_i = 16'h0000;

  always #5 clk_i = ~clk_i;

  packet_deframer_crc_check_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  cfg_t            cfg_shadow = '{8'h00, 8'hFF, 8'h01, 8'hA5, 8'h5A, 16'hFFFF};
  phase_e          rx_phase = PH_SOF0;
  logic [6:0]      rx_pos = '0;
  logic [6:0]      len_held = '0;
  logic [5:0][7:0] hdr_seen = '0;
  logic [15:0]     crc_run = 16'hFFFF;
  logic [7:0]      crc_lo = '0;
  logic [7:0]      pay_mem [PAY_MAX];

  deframe_word_t   expected_words [$];
  deframe_word_t   step_words [$];
  bit              divert_words = 1'b0;
  int unsigned     err_count = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     burst_left = 1;
  int unsigned     hold_cycles = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic logic [15:0] ccitt_advance(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  task automatic note_word(input event_e k, input logic [6:0] len, input logic [7:0] pb,
                           input logic [5:0] idx, input logic last);
    deframe_word_t w;
    w.kind  = k;
    w.hdr   = hdr_seen;
    w.len   = len;
    w.pbyte = pb;
    w.idx   = idx;
    w.last  = last;
    step_words.push_back(w);
  endtask

  // advance the deframer state by one link byte
  task automatic absorb_rx_byte(input logic [7:0] b);
    int k;
    case (rx_phase)
      PH_SOF1: begin
        if (b == cfg_shadow.sof1) begin
          rx_pos   = '0;
          crc_run  = cfg_shadow.crc_init;
          rx_phase = PH_HDR;
        end else if (b != cfg_shadow.sof0) begin
          rx_phase = PH_SOF0;
        end
      end
      PH_HDR: begin
        crc_run = ccitt_advance(crc_run, b);
        if (rx_pos < 6) begin
          hdr_seen[rx_pos] = b;
          rx_pos++;
        end else begin
          rx_pos = '0;
          if (b > PAY_MAX) begin
            note_word(EV_LEN, (b > 127) ? 7'd127 : b[6:0], 8'h00, 6'd0, 1'b1);
            len_held = '0;
            rx_phase = PH_SOF0;
          end else begin
            len_held = b[6:0];
            rx_phase = (b != 0) ? PH_PAY : PH_CRCL;
          end
        end
      end
      PH_PAY: begin
        crc_run = ccitt_advance(crc_run, b);
        pay_mem[rx_pos[5:0]] = b;
        rx_pos++;
        if (rx_pos >= len_held || rx_pos >= PAY_MAX) begin
          rx_pos   = '0;
          rx_phase = PH_CRCL;
        end
      end
      PH_CRCL: begin
        crc_lo   = b;
        rx_phase = PH_CRCH;
      end
      PH_CRCH: begin
        if ({b, crc_lo} != crc_run) begin
          note_word(EV_CRC, len_held, 8'h00, 6'd0, 1'b1);
        end else if (hdr_seen[2] != cfg_shadow.self_node &&
                     hdr_seen[2] != cfg_shadow.bcast_node) begin
          note_word(EV_NADDR, len_held, 8'h00, 6'd0, 1'b1);
        end else if (hdr_seen[0] != cfg_shadow.version) begin
          note_word(EV_VER, len_held, 8'h00, 6'd0, 1'b1);
        end else if (len_held == 0) begin
          note_word(EV_PKT, 7'd0, 8'h00, 6'd0, 1'b1);
        end else begin
          for (k = 0; k < len_held; k++)
            note_word(EV_PKT, len_held, pay_mem[k], 6'(k), (k + 1) == len_held);
        end
        rx_phase = PH_SOF0;
        rx_pos   = '0;
      end
      default: rx_phase = (b == cfg_shadow.sof0) ? PH_SOF1 : PH_SOF0;
    endcase
  endtask

  // offer one word, wait for the handshake, then idle per the burst pattern
  task automatic push_byte(input logic [7:0] b);
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_rx_byte(b);
    if (divert_words) step_words.delete();
    else while (step_words.size() != 0) expected_words.push_back(step_words.pop_front());
    bytes_sent++;
    @(negedge clk_i);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_frame(input frame_t f);
    logic [7:0]      body [$];
    logic [6:0][7:0] hb;
    logic [15:0]     crc;
    logic [7:0]      pick;
    logic [7:0]      pb;
    deframe_word_t   w;
    int              k;
    if (f.broken) begin
      pick = $urandom;
      while (pick == cfg_shadow.sof0 || pick == cfg_shadow.sof1) pick = $urandom;
      body.push_back(cfg_shadow.sof0);
      body.push_back(pick);
    end
    repeat (f.n_sof) body.push_back(cfg_shadow.sof0);
    body.push_back(cfg_shadow.sof1);
    hb  = {f.len, f.seq, f.flags, f.mtype, f.dst, f.src, f.ver};
    crc = cfg_shadow.crc_init;
    for (k = 0; k < 7; k++) begin
      body.push_back(hb[k]);
      crc = ccitt_advance(crc, hb[k]);
    end
    // an oversized length ends the frame at the header
    if (f.len <= PAY_MAX) begin
      for (k = 0; k < f.len; k++) begin
        pb = 8'(f.pay_base + k * f.pay_step);
        body.push_back(pb);
        crc = ccitt_advance(crc, pb);
      end
      if (f.crc_fault == 2'd1) crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
      if (f.crc_fault == 2'd2) crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end
    if (f.cut != 0) while (body.size() > f.cut) body.delete(body.size() - 1);
    if (f.typed) begin
      w.kind  = f.kind;
      w.hdr   = hb[5:0];
      w.len   = (f.len > 127) ? 7'd127 : f.len[6:0];
      w.pbyte = 8'h00;
      w.idx   = 6'd0;
      w.last  = 1'b1;
      expected_words.push_back(w);
      divert_words = 1'b1;
    end
    for (k = 0; k < body.size(); k++) push_byte(body[k]);
    divert_words = 1'b0;
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int     r;
    f.n_sof  = (cfg_shadow.sof0 == cfg_shadow.sof1) ? 2'd1 : 2'($urandom_range(1, 3));
    f.broken = ($urandom_range(0, 9) == 0);
    r        = $urandom_range(0, 9);
    f.dst    = (r < 5) ? cfg_shadow.self_node : (r < 7) ? cfg_shadow.bcast_node : 8'($urandom);
    f.ver    = ($urandom_range(0, 19) < 17) ? cfg_shadow.version : 8'($urandom);
    f.src    = 8'($urandom);
    f.mtype  = 8'($urandom);
    f.flags  = 8'($urandom);
    f.seq    = 8'($urandom);
    r        = $urandom_range(0, 19);
    if (r < 14)       f.len = 8'($urandom_range(0, 8));
    else if (r < 18)  f.len = 8'($urandom_range(9, 63));
    else if (r == 18) f.len = 8'd64;
    else              f.len = 8'($urandom_range(65, 255));
    f.pay_base  = 8'($urandom);
    f.pay_step  = 8'($urandom);
    r           = $urandom_range(0, 19);
    f.crc_fault = (r < 17) ? 2'd0 : (r < 19) ? 2'd1 : 2'd2;
    f.cut       = ($urandom_range(0, 11) == 0) ? 7'($urandom_range(1, 12)) : 7'd0;
    f.typed     = 1'b0;
    f.kind      = EV_PKT;
    return f;
  endfunction

  // drop valid and wait until every expected word is out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (TAIL) @(negedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_idx_e r;
    int       i;
    for (i = 0; i < 6; i++) begin
      r = cfg_idx_e'(i);
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= r;
      case (r)
        CFG_SELF:    cfg_wdata_i <= {8'h00, c.self_node};
        CFG_BCAST:   cfg_wdata_i <= {8'h00, c.bcast_node};
        CFG_VERSION: cfg_wdata_i <= {8'h00, c.version};
        CFG_SOF0:    cfg_wdata_i <= {8'h00, c.sof0};
        CFG_SOF1:    cfg_wdata_i <= {8'h00, c.sof1};
        default:     cfg_wdata_i <= c.crc_init;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : watch_output
    deframe_word_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected, kind %0d", m_axis_tuser));
      end else begin
        w = expected_words.pop_front();
        check_field("event_kind", m_axis_tuser, w.kind);
        check_field("version", m_axis_tdata[7:0], w.hdr[0]);
        check_field("source", m_axis_tdata[15:8], w.hdr[1]);
        check_field("destination", m_axis_tdata[23:16], w.hdr[2]);
        check_field("message_type", m_axis_tdata[31:24], w.hdr[3]);
        check_field("flag_bits", m_axis_tdata[39:32], w.hdr[4]);
        check_field("sequence_res", m_axis_tdata[47:40], w.hdr[5]);
        check_field("payload_length", m_axis_tdata[54:48], w.len);
        check_field("payload_byte", m_axis_tdata[62:55], w.pbyte);
        check_field("byte_index", m_axis_tdata[68:63], w.idx);
        check_field("last", m_axis_tlast, w.last);
      end
    end
  end

  // receiver: random stall segments, plus a long hold-off on request
  initial begin : receiver
    int unsigned seg_left;
    int unsigned mode;
    seg_left = 0;
    mode     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
          default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    frame_t      probes [16];
    frame_t      f;
    cfg_t        c;
    int          p;
    int          i;
    int unsigned phase_start;

    // n_sof brk ver src dst type flags seq len base step fault cut typed kind
    probes[0]  = '{2'd1, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0,
                   8'h00, 8'h00, 2'd0, 7'd0, 1'b1, EV_PKT};
    probes[1]  = '{2'd2, 1'b0, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1,
                   8'h00, 8'h00, 2'd0, 7'd0, 1'b0, EV_PKT};
    probes[2]  = '{2'd1, 1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd64,
                   8'hFF, 8'h01, 2'd0, 7'd0, 1'b0, EV_PKT};
    probes[3]  = '{2'd1, 1'b1, 8'h01, 8'h12, 8'h00, 8'h34, 8'h56, 8'h78, 8'd3,
                   8'h00, 8'hFF, 2'd0, 7'd0, 1'b0, EV_PKT};
    probes[4]  = '{2'd1, 1'b0, 8'h01, 8'h0A, 8'h00, 8'h0B, 8'h0C, 8'h0D, 8'd65,
                   8'h00, 8'h00, 2'd0, 7'd0, 1'b1, EV_LEN};
    probes[5]  = '{2'd1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255,
                   8'h00, 8'h00, 2'd0, 7'd0, 1'b1, EV_LEN};
    probes[6]  = '{2'd1, 1'b0, 8'h01, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'd128,
                   8'h00, 8'h00, 2'd0, 7'd0, 1'b1, EV_LEN};
    probes[7]  = '{2'd1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd127,
                   8'h00, 8'h00, 2'd0, 7'd0, 1'b1, EV_LEN};
    probes[8]  = '{2'd1, 1'b0, 8'h01, 8'h41, 8'h00, 8'h42, 8'h43, 8'h44, 8'd4,
                   8'h10, 8'h03, 2'd1, 7'd0, 1'b1, EV_CRC};
    probes[9]  = '{2'd1, 1'b0, 8'h01, 8'h51, 8'hFF, 8'h52, 8'h53, 8'h54, 8'd0,
                   8'h00, 8'h00, 2'd2, 7'd0, 1'b1, EV_CRC};
    probes[10] = '{2'd1, 1'b0, 8'h01, 8'h61, 8'h37, 8'h62, 8'h63, 8'h64, 8'd5,
                   8'h20, 8'h05, 2'd0, 7'd0, 1'b1, EV_NADDR};
    probes[11] = '{2'd1, 1'b0, 8'h09, 8'h71, 8'h37, 8'h72, 8'h73, 8'h74, 8'd0,
                   8'h00, 8'h00, 2'd0, 7'd0, 1'b1, EV_NADDR};
    probes[12] = '{2'd1, 1'b0, 8'h00, 8'h81, 8'h00, 8'h82, 8'h83, 8'h84, 8'd3,
                   8'h30, 8'h07, 2'd0, 7'd0, 1'b1, EV_VER};
    probes[13] = '{2'd1, 1'b0, 8'hFF, 8'h91, 8'hFF, 8'h92, 8'h93, 8'h94, 8'd2,
                   8'h40, 8'h09, 2'd0, 7'd0, 1'b1, EV_VER};
    probes[14] = '{2'd3, 1'b0, 8'h01, 8'hA1, 8'hFF, 8'hA2, 8'hA3, 8'hA4, 8'd2,
                   8'h7F, 8'h81, 2'd0, 7'd0, 1'b0, EV_PKT};
    probes[15] = '{2'd1, 1'b0, 8'h01, 8'hB1, 8'h00, 8'hB2, 8'hB3, 8'hB4, 8'd10,
                   8'h00, 8'h11, 2'd0, 7'd9, 1'b0, EV_PKT};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < 16; i++) send_frame(probes[i]);
    settle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: c = '{8'h00, 8'hFF, 8'h01, 8'hA5, 8'h5A, 16'hFFFF};
        1: c = '0;
        2: c = '1;
        default: begin
          c.self_node  = 8'($urandom);
          c.bcast_node = 8'($urandom);
          c.version    = 8'($urandom);
          c.sof0       = 8'($urandom);
          c.sof1       = 8'($urandom);
          c.crc_init   = 16'($urandom);
        end
      endcase
      load_config(c);
      phase_start = bytes_sent;
      // block the output while a full-size packet replays and the next one arrives
      if (p == 3) begin
        hold_cycles = HOLD_OFF;
        for (i = 0; i < 2; i++) begin
          f           = random_frame();
          f.broken    = 1'b0;
          f.dst       = cfg_shadow.self_node;
          f.ver       = cfg_shadow.version;
          f.len       = (i == 0) ? 8'd64 : 8'd4;
          f.crc_fault = 2'd0;
          f.cut       = 7'd0;
          send_frame(f);
        end
      end
      while (bytes_sent - phase_start < 8) begin
        if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        send_frame(random_frame());
      end
      settle();
    end

    if (err_count == 0) begin
      $display("packet_deframer_crc_check_core_tb: clean");
    end else begin
      $display("packet_deframer_crc_check_core_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("packet_deframer_crc_check_core_tb: errors");
    $finish;
  end

endmodule
